// File: src/rrdo_pkg.sv
`timescale 1ns / 1ps
package rrdo_pkg;

  localparam int RING_BYTES       = 8192;
  localparam int RING_AW          = $clog2(RING_BYTES);
  localparam int MAX_RECORD_BYTES = 255;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_DATA    = 3'd0,
    STS_EMPTY   = 3'd1,
    STS_STORED  = 3'd2,
    STS_DISCARD = 3'd3,
    STS_DROPPED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISC,
    ST_WR_LEN,
    ST_WR_DATA,
    ST_RD_LEN,
    ST_RD_BYTE
  } state_t;

  typedef struct packed {
    action_t    act;
    logic [7:0] data;
    logic       eor;
  } cmd_t;

endpackage

// File: src/record_ring_drop_oldest_top.sv
`timescale 1ns / 1ps
// Write: stage a byte; commit: discard oldest records, then store length and bytes.
// Read: length, then payload bytes; results leave through a one-entry output register.
// A two-entry command queue lets the input side run ahead of the back-end sequencer.
// Throughput is set by the ring writes and reads, one byte per cycle when output is free.
// Reset (rst_n low, synchronous) empties the ring, the queue and the staged record.
module record_ring_drop_oldest_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic [1:0]  in_tuser,   // action
  input  logic        in_tlast,   // end_of_record
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_word[31:0], byte_count[34:32], zero pad
  output logic        out_tlast,  // last_word
  output logic [2:0]  out_tuser   // status
);

  logic           cmd_valid, cmd_pop;
  rrdo_pkg::cmd_t cmd;

  rrdo_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .cmd_valid, .cmd, .cmd_pop
  );

  rrdo_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

endmodule

// File: src/rrdo_front.sv
`timescale 1ns / 1ps
module rrdo_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic [1:0]      in_tuser,
  input  logic            in_tlast,
  output logic            cmd_valid,
  output rrdo_pkg::cmd_t  cmd,
  input  logic            cmd_pop
);

  rrdo_pkg::cmd_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_tready = (cnt_r != 2'd2);
  // unused action codes are swallowed here
  assign push      = in_tvalid && in_tready &&
                     (rrdo_pkg::action_t'(in_tuser) != rrdo_pkg::ACT_NONE);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{act: rrdo_pkg::action_t'(in_tuser), data: in_tdata, eor: in_tlast};
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

// File: src/rrdo_back.sv
`timescale 1ns / 1ps
module rrdo_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  rrdo_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [39:0]    out_tdata,
  output logic           out_tlast,
  output logic [2:0]     out_tuser
);

  localparam int AW = rrdo_pkg::RING_AW;
  localparam int OW = AW + 1;

  logic [7:0] ring_mem [rrdo_pkg::RING_BYTES];
  logic [7:0] stage_mem [256];

  rrdo_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [OW-1:0] occ_r, occ_nxt, occ1;
  logic [8:0]    staged_r, staged_nxt, staged_inc;
  logic [7:0]    size_r, size_nxt, idx_r, idx_nxt, rem_r, rem_nxt, len;
  logic [1:0]    j_r, j_nxt;
  logic [31:0]   word_r, word_nxt, word_merge;
  logic          disc_r, disc_nxt;
  logic [7:0]    rq, st_q, st_raddr;
  logic          ring_we, stage_we;
  logic [7:0]    ring_wdata;
  logic          fits, out_free, emit, emit_last;
  logic [31:0]   emit_word;
  logic [2:0]    emit_cnt, emit_sts;
  logic          ov_r;
  logic [31:0]   ow_r;
  logic [2:0]    oc_r, os_r;
  logic          ol_r;

  assign out_free   = !ov_r || out_tready;
  assign occ1       = occ_r - OW'(1);
  assign len        = ({{(OW-8){1'b0}}, rq} > occ1) ? occ1[7:0] : rq;
  assign fits       = (occ_r == '0) ||
                      ((AW+2)'(size_r) + (AW+2)'(1) + (AW+2)'(occ_r)
                       <= (AW+2)'(rrdo_pkg::RING_BYTES));
  assign staged_inc = (staged_r <= 9'(rrdo_pkg::MAX_RECORD_BYTES)) ?
                      staged_r + 9'd1 : staged_r;
  assign word_merge = word_r | ({24'd0, rq} << {j_r, 3'b000});

  always_comb begin
    state_nxt  = state_r;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    occ_nxt    = occ_r;
    staged_nxt = staged_r;
    size_nxt   = size_r;
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    j_nxt      = j_r;
    word_nxt   = word_r;
    disc_nxt   = disc_r;
    cmd_pop    = 1'b0;
    ring_we    = 1'b0;
    ring_wdata = st_q;
    stage_we   = 1'b0;
    st_raddr   = idx_r;
    emit       = 1'b0;
    emit_word  = 32'd0;
    emit_cnt   = 3'd0;
    emit_last  = 1'b1;
    emit_sts   = rrdo_pkg::STS_DATA;
    case (state_r)
      rrdo_pkg::ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.act)
            rrdo_pkg::ACT_WRITE: begin
              stage_we = (staged_r < 9'(rrdo_pkg::MAX_RECORD_BYTES));
              if (cmd.eor) begin
                staged_nxt = 9'd0;
                if (staged_inc > 9'(rrdo_pkg::MAX_RECORD_BYTES)) begin
                  emit     = 1'b1;
                  emit_sts = rrdo_pkg::STS_DROPPED;
                end else begin
                  size_nxt  = staged_inc[7:0];
                  disc_nxt  = 1'b0;
                  state_nxt = rrdo_pkg::ST_DISC;
                end
              end else begin
                staged_nxt = staged_inc;
              end
            end
            rrdo_pkg::ACT_READ: begin
              if (occ_r == '0) begin
                emit     = 1'b1;
                emit_sts = rrdo_pkg::STS_EMPTY;
              end else begin
                word_nxt  = 32'd0;
                j_nxt     = 2'd0;
                state_nxt = rrdo_pkg::ST_RD_LEN;
              end
            end
            rrdo_pkg::ACT_FLUSH: begin
              rp_nxt  = '0;
              wp_nxt  = '0;
              occ_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      rrdo_pkg::ST_DISC: begin
        // skip the oldest record by pointer arithmetic; rq holds its length byte
        if (!fits) begin
          rp_nxt   = rp_r + AW'(1) + AW'(len);
          occ_nxt  = occ1 - OW'(len);
          disc_nxt = 1'b1;
        end else begin
          state_nxt = rrdo_pkg::ST_WR_LEN;
        end
      end
      rrdo_pkg::ST_WR_LEN: begin
        ring_we    = 1'b1;
        ring_wdata = size_r;
        wp_nxt     = wp_r + AW'(1);
        occ_nxt    = occ_r + OW'(1);
        idx_nxt    = 8'd0;
        st_raddr   = 8'd0;
        state_nxt  = rrdo_pkg::ST_WR_DATA;
      end
      rrdo_pkg::ST_WR_DATA: begin
        if (idx_r != size_r - 8'd1 || out_free) begin
          ring_we  = 1'b1;
          wp_nxt   = wp_r + AW'(1);
          occ_nxt  = occ_r + OW'(1);
          idx_nxt  = idx_r + 8'd1;
          st_raddr = idx_r + 8'd1;
          if (idx_r == size_r - 8'd1) begin
            emit      = 1'b1;
            emit_sts  = disc_r ? rrdo_pkg::STS_DISCARD : rrdo_pkg::STS_STORED;
            state_nxt = rrdo_pkg::ST_IDLE;
          end
        end
      end
      rrdo_pkg::ST_RD_LEN: begin
        rp_nxt  = rp_r + AW'(1);
        occ_nxt = occ1 - OW'(len);
        rem_nxt = len;
        if (len == 8'd0) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_sts  = rrdo_pkg::STS_DATA;
            state_nxt = rrdo_pkg::ST_IDLE;
          end else begin
            rp_nxt  = rp_r;
            occ_nxt = occ_r;
          end
        end else begin
          state_nxt = rrdo_pkg::ST_RD_BYTE;
        end
      end
      rrdo_pkg::ST_RD_BYTE: begin
        if (!((j_r == 2'd3 || rem_r == 8'd1) && !out_free)) begin
          rp_nxt   = rp_r + AW'(1);
          rem_nxt  = rem_r - 8'd1;
          j_nxt    = j_r + 2'd1;
          word_nxt = word_merge;
          if (j_r == 2'd3 || rem_r == 8'd1) begin
            emit      = 1'b1;
            emit_word = word_merge;
            emit_cnt  = {1'b0, j_r} + 3'd1;
            emit_last = (rem_r == 8'd1);
            word_nxt  = 32'd0;
            j_nxt     = 2'd0;
            if (rem_r == 8'd1) state_nxt = rrdo_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = rrdo_pkg::ST_IDLE;
    endcase
  end

  // ring read uses rp_nxt; rq shows ring[rp_r] unless that byte was just written
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[wp_r] <= ring_wdata;
    rq <= ring_mem[rp_nxt];
  end

  always_ff @(posedge clk) begin
    if (stage_we) stage_mem[staged_r[7:0]] <= cmd.data;
    st_q <= stage_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    size_r <= size_nxt;
    idx_r  <= idx_nxt;
    rem_r  <= rem_nxt;
    j_r    <= j_nxt;
    word_r <= word_nxt;
    disc_r <= disc_nxt;
    if (emit) begin
      ow_r <= emit_word;
      oc_r <= emit_cnt;
      ol_r <= emit_last;
      os_r <= emit_sts;
    end
    if (!rst_n) begin
      state_r  <= rrdo_pkg::ST_IDLE;
      rp_r     <= '0;
      wp_r     <= '0;
      occ_r    <= '0;
      staged_r <= 9'd0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rp_r     <= rp_nxt;
      wp_r     <= wp_nxt;
      occ_r    <= occ_nxt;
      staged_r <= staged_nxt;
      if (emit) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, oc_r, ow_r};
  assign out_tlast  = ol_r;
  assign out_tuser  = os_r;

endmodule

// File: src/rrdo_checker.sv
`timescale 1ns / 1ps
module rrdo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast,
  input logic [2:0]  out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != rrdo_pkg::STS_DATA |-> out_tlast && out_tdata[34:0] == 35'd0)
    else $error("status item not single and empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[34:32] <= 3'd4)
    else $error("byte count out of range");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[34:32] == 3'd4 && out_tuser == rrdo_pkg::STS_DATA)
    else $error("inner word not full");

endmodule

bind record_ring_drop_oldest_top rrdo_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
);

// File: tb/record_ring_drop_oldest_top_tb.sv
`timescale 1ns / 1ps
module record_ring_drop_oldest_top_tb;

  localparam int IDLE_PCT   = 8;
  localparam int STALL_LIM  = 5000;
  localparam int QUIET_FROM = 150;
  localparam int QUIET_TO   = 400;

  typedef struct {
    rrdo_pkg::action_t act;
    logic [7:0]        data;
    logic              eor;
    bit                drain;  // hold off until all results are back
  } stim_t;

  typedef struct {
    logic [31:0]       word;
    logic [2:0]        cnt;
    logic              last;
    rrdo_pkg::status_t sts;
  } rec_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;

  stim_t     pending_q[$];
  rec_word_t expected_q[$];

  // predictor state
  logic [7:0] ring_mem [rrdo_pkg::RING_BYTES];
  logic [7:0] stage_mem [rrdo_pkg::MAX_RECORD_BYTES];
  int rd_ptr, wr_ptr, used_bytes, stage_cnt;

  int errors, cycle_cnt, stall_cnt, n_items, n_words, n_discards, n_drops;

  record_ring_drop_oldest_top DUT (.*);

  always #6 clk = ~clk;

  function automatic int take_oldest(output logic [7:0] buf_o [256]);
    int len;
    len = int'(ring_mem[rd_ptr]);
    rd_ptr = (rd_ptr + 1) & (rrdo_pkg::RING_BYTES - 1);
    used_bytes--;
    if (len > used_bytes) len = used_bytes;
    for (int i = 0; i < len; i++) begin
      buf_o[i] = ring_mem[rd_ptr];
      rd_ptr = (rd_ptr + 1) & (rrdo_pkg::RING_BYTES - 1);
    end
    used_bytes -= len;
    return len;
  endfunction

  function automatic void put_ring(logic [7:0] b);
    ring_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) & (rrdo_pkg::RING_BYTES - 1);
    used_bytes++;
  endfunction

  function automatic void predict_item(stim_t s);
    logic [7:0] bytes [256];
    rec_word_t r;
    int size, len, nw;
    bit dropped_old;
    r.word = '0; r.cnt = '0; r.last = 1'b1;
    case (s.act)
      rrdo_pkg::ACT_WRITE: begin
        if (stage_cnt < rrdo_pkg::MAX_RECORD_BYTES) stage_mem[stage_cnt] = s.data;
        if (stage_cnt <= rrdo_pkg::MAX_RECORD_BYTES) stage_cnt++;
        if (s.eor) begin
          size = stage_cnt;
          stage_cnt = 0;
          if (size == 0 || size > rrdo_pkg::MAX_RECORD_BYTES) begin
            r.sts = rrdo_pkg::STS_DROPPED;
          end else begin
            dropped_old = 0;
            while (used_bytes > 0 && size + 1 > rrdo_pkg::RING_BYTES - used_bytes) begin
              void'(take_oldest(bytes));
              dropped_old = 1;
            end
            put_ring(size[7:0]);
            for (int i = 0; i < size; i++) put_ring(stage_mem[i]);
            r.sts = dropped_old ? rrdo_pkg::STS_DISCARD : rrdo_pkg::STS_STORED;
          end
          expected_q.push_back(r);
        end
      end
      rrdo_pkg::ACT_READ: begin
        if (used_bytes == 0) begin
          r.sts = rrdo_pkg::STS_EMPTY;
          expected_q.push_back(r);
        end else begin
          len = take_oldest(bytes);
          r.sts = rrdo_pkg::STS_DATA;
          if (len == 0) begin
            expected_q.push_back(r);
          end else begin
            nw = (len + 3) / 4;
            for (int w = 0; w < nw; w++) begin
              r.word = '0; r.cnt = '0;
              for (int j = 0; j < 4; j++)
                if (w * 4 + j < len) begin
                  r.word[8*j +: 8] = bytes[w * 4 + j];
                  r.cnt++;
                end
              r.last = (w + 1 == nw);
              expected_q.push_back(r);
            end
          end
        end
      end
      rrdo_pkg::ACT_FLUSH: begin
        rd_ptr = 0; wr_ptr = 0; used_bytes = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic bit may_idle();
    return !(cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) &&
           ($urandom_range(99) < IDLE_PCT);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_item('{rrdo_pkg::action_t'(in_tuser), in_tdata, in_tlast, 1'b0});
        n_items++;
      end
      if (!in_tvalid || in_tready) begin
        while (pending_q.size() > 0 && pending_q[0].drain && expected_q.size() == 0)
          void'(pending_q.pop_front());
        if (pending_q.size() == 0 || pending_q[0].drain || may_idle()) begin
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_q[0].act;
          in_tdata  <= pending_q[0].data;
          in_tlast  <= pending_q[0].eor;
          void'(pending_q.pop_front());
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rec_word_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: word=%h", out_tdata[31:0]);
          errors++;
        end else begin
          e = expected_q.pop_front();
          n_words++;
          if (out_tdata[31:0] !== e.word) begin
            $error("out_word: expected %h, got %h", e.word, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[34:32] !== e.cnt) begin
            $error("byte_count: expected %0d, got %0d", e.cnt, out_tdata[34:32]);
            errors++;
          end
          if (out_tlast !== e.last) begin
            $error("last_word: expected %0d, got %0d", e.last, out_tlast);
            errors++;
          end
          if (out_tuser !== e.sts) begin
            $error("status: expected %0d, got %0d", e.sts, out_tuser);
            errors++;
          end
          if (e.sts == rrdo_pkg::STS_DISCARD) n_discards++;
          if (e.sts == rrdo_pkg::STS_DROPPED) n_drops++;
        end
      end
      out_tready <= !may_idle();
    end
  end

  // watchdog on stalled handshakes
  always @(posedge clk) begin
    cycle_cnt++;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= STALL_LIM) begin
      $display("timeout: %0d results outstanding", expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_item(rrdo_pkg::action_t a, logic [7:0] d, logic e);
    pending_q.push_back('{a, d, e, 1'b0});
  endtask

  task automatic push_record(int len, bit commit);
    for (int i = 0; i < len; i++)
      push_item(rrdo_pkg::ACT_WRITE, 8'($urandom_range(255)), commit && (i == len - 1));
  endtask

  task automatic push_drain();
    pending_q.push_back('{rrdo_pkg::ACT_NONE, 8'h00, 1'b0, 1'b1});
  endtask

  initial begin
    int pick, queued;
    errors = 0; cycle_cnt = 0; stall_cnt = 0;
    n_items = 0; n_words = 0; n_discards = 0; n_drops = 0;
    rd_ptr = 0; wr_ptr = 0; used_bytes = 0; stage_cnt = 0;

    // directed: empty read, byte extremes, odd lengths, flush, unused code
    push_item(rrdo_pkg::ACT_READ, 8'h00, 1'b0);
    push_item(rrdo_pkg::ACT_WRITE, 8'h00, 1'b1);
    push_item(rrdo_pkg::ACT_WRITE, 8'hff, 1'b1);
    push_item(rrdo_pkg::ACT_WRITE, 8'ha5, 1'b0);
    push_item(rrdo_pkg::ACT_WRITE, 8'h5a, 1'b0);
    push_item(rrdo_pkg::ACT_WRITE, 8'h01, 1'b0);
    push_item(rrdo_pkg::ACT_WRITE, 8'h80, 1'b0);
    push_item(rrdo_pkg::ACT_WRITE, 8'h7f, 1'b1);
    push_item(rrdo_pkg::ACT_READ, 8'hff, 1'b1);
    push_item(rrdo_pkg::ACT_READ, 8'h00, 1'b0);
    push_item(rrdo_pkg::ACT_READ, 8'h00, 1'b0);
    push_item(rrdo_pkg::ACT_READ, 8'h00, 1'b0);
    push_record(3, 1);
    push_item(rrdo_pkg::ACT_WRITE, 8'h11, 1'b0);
    push_item(rrdo_pkg::ACT_FLUSH, 8'hff, 1'b1);   // staged byte survives the flush
    push_item(rrdo_pkg::ACT_READ, 8'h00, 1'b0);
    push_item(rrdo_pkg::ACT_NONE, 8'hff, 1'b1);
    push_item(rrdo_pkg::ACT_WRITE, 8'h22, 1'b1);
    push_item(rrdo_pkg::ACT_READ, 8'h00, 1'b0);
    push_drain();

    // random mix, mostly short records
    queued = 0;
    while (queued < 250) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        pick = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 9);
        push_record(pick, 1);
        queued += pick;
      end else if (pick < 58) begin
        push_record($urandom_range(1, 3), 0);
        queued++;
      end else if (pick < 88) begin
        push_item(rrdo_pkg::ACT_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
        queued++;
      end else if (pick < 93) begin
        push_item(rrdo_pkg::ACT_FLUSH, 8'($urandom_range(255)), 1'($urandom_range(1)));
        queued++;
      end else if (pick < 96) begin
        push_item(rrdo_pkg::ACT_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        push_drain();
      end
    end
    push_drain();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_q.size() == 0 && !in_tvalid && expected_q.size() == 0);
    repeat (300) @(posedge clk);

    $display("%0d items sent, %0d results checked", n_items, n_words);
    $display("%0d commits discarded old records, %0d records dropped", n_discards, n_drops);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
